/* design/lemd_pkg.sv */
// ----------------------------------------------------------------------------
// lemd_pkg
// Shared types and constants of the light edge marker detector.
// ----------------------------------------------------------------------------
package lemd_pkg;

    localparam int WINDOW_LENGTH = 10;
    localparam int IDX_W         = $clog2(WINDOW_LENGTH);
    localparam int SAMPLE_W      = 10;
    localparam int CLS_W         = 2;
    localparam int STATUS_W      = 2;

    localparam logic signed [CLS_W-1:0] CLS_FLAT = 2'sb00;
    localparam logic signed [CLS_W-1:0] CLS_RISE = 2'sb01;
    localparam logic signed [CLS_W-1:0] CLS_FALL = 2'sb11;

    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MARKER   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POSSIBLE = 2'd2;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd5;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_RUN,
        SCAN_DONE
    } scan_state_t;

    typedef struct packed {
        logic                    start;
        logic signed [CLS_W-1:0] cls;
        logic                    take;
    } scan_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [STATUS_W-1:0] status;
    } scan_rsp_t;

endpackage

/* design/lemd_scan.sv */
// ----------------------------------------------------------------------------
// lemd_scan
// Class ring and sequential scan, one ring entry per cycle, oldest first.
// ----------------------------------------------------------------------------
module lemd_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  lemd_pkg::scan_req_t req,
    output lemd_pkg::scan_rsp_t rsp
);
    import lemd_pkg::*;

    scan_state_t             state_reg, state_next;
    logic signed [CLS_W-1:0] ring_reg [WINDOW_LENGTH];
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic                    rise_run_reg, rise_run_next;
    logic                    fall_run_reg, fall_run_next;
    logic                    rise_rep_reg, rise_rep_next;
    logic                    fall_rep_reg, fall_rep_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic signed [CLS_W-1:0] cur;
    logic [IDX_W-1:0]        pos_inc;
    logic [IDX_W-1:0]        idx_inc;

    assign cur     = ring_reg[idx_reg];
    assign pos_inc = (pos_reg == IDX_W'(WINDOW_LENGTH - 1)) ? '0 : pos_reg + 1'b1;
    assign idx_inc = (idx_reg == IDX_W'(WINDOW_LENGTH - 1)) ? '0 : idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LENGTH; i++)
            begin
                ring_reg[i] <= CLS_FLAT;
            end
            pos_reg <= '0;
        end
        else
        begin
            if (state_reg == SCAN_IDLE && req.start)
            begin
                ring_reg[pos_reg] <= req.cls;
            end
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        rise_run_reg <= rise_run_next;
        fall_run_reg <= fall_run_next;
        rise_rep_reg <= rise_rep_next;
        fall_rep_reg <= fall_rep_next;
        status_reg   <= status_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        rise_run_next = rise_run_reg;
        fall_run_next = fall_run_reg;
        rise_rep_next = rise_rep_reg;
        fall_rep_next = fall_rep_reg;
        status_next   = status_reg;
        case (state_reg)
            SCAN_IDLE:
            begin
                if (req.start)
                begin
                    // oldest entry sits just after the slot being written
                    idx_next      = pos_inc;
                    pos_next      = pos_inc;
                    cnt_next      = '0;
                    rise_run_next = 1'b0;
                    fall_run_next = 1'b0;
                    rise_rep_next = 1'b0;
                    fall_rep_next = 1'b0;
                    status_next   = ST_NONE;
                    state_next    = SCAN_RUN;
                end
            end
            SCAN_RUN:
            begin
                if (cur == CLS_RISE)
                begin
                    if (rise_run_reg && fall_rep_reg)
                    begin
                        status_next = ST_MARKER;
                    end
                    else if (rise_run_reg)
                    begin
                        status_next   = ST_POSSIBLE;
                        rise_rep_next = 1'b1;
                    end
                    rise_run_next = 1'b1;
                    fall_run_next = 1'b0;
                end
                else if (cur == CLS_FALL)
                begin
                    if (fall_run_reg && rise_rep_reg)
                    begin
                        status_next = ST_MARKER;
                    end
                    else if (fall_run_reg)
                    begin
                        status_next   = ST_POSSIBLE;
                        fall_rep_next = 1'b1;
                    end
                    rise_run_next = 1'b0;
                    fall_run_next = 1'b1;
                end
                else
                begin
                    rise_run_next = 1'b0;
                    fall_run_next = 1'b0;
                end
                idx_next = idx_inc;
                cnt_next = cnt_reg + 1'b1;
                if (status_next == ST_MARKER || cnt_reg == IDX_W'(WINDOW_LENGTH - 1))
                begin
                    state_next = SCAN_DONE;
                end
            end
            SCAN_DONE:
            begin
                if (req.take)
                begin
                    state_next = SCAN_IDLE;
                end
            end
            default:
            begin
                state_next = SCAN_IDLE;
            end
        endcase
    end

    assign rsp.busy   = (state_reg != SCAN_IDLE);
    assign rsp.done   = (state_reg == SCAN_DONE);
    assign rsp.status = status_reg;

endmodule

/* design/light_edge_marker_detector_top.sv */
// ----------------------------------------------------------------------------
// light_edge_marker_detector_top
// Classifies each light sample against the previous one and scans the ring of
// recent classes for repeated rise and fall runs.
// The ring scan reads one entry per cycle, up to WINDOW_LENGTH entries, ending
// early on a marker. The input stalls while a scan runs and until its result is
// taken to the output, so a new word is accepted only after that.
// Reset: threshold 5, previous sample 0, ring all flat, write slot 0.
// ----------------------------------------------------------------------------
module light_edge_marker_detector_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lemd_pkg::SAMPLE_W-1:0]        cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lemd_pkg::SAMPLE_W-1:0]        light_sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lemd_pkg::STATUS_W-1:0]        marker_status,
    output logic signed [lemd_pkg::CLS_W-1:0]    edge_class
);
    import lemd_pkg::*;

    logic [SAMPLE_W-1:0]     threshold_reg;
    logic [SAMPLE_W-1:0]     prev_reg;
    logic signed [CLS_W-1:0] cls_reg;
    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     status_out_reg;
    logic signed [CLS_W-1:0] cls_out_reg;
    logic                    in_take;
    logic signed [SAMPLE_W+1:0] diff;
    logic signed [SAMPLE_W+1:0] thr;
    logic signed [CLS_W-1:0] cls;
    scan_req_t               req;
    scan_rsp_t               rsp;

    assign diff = $signed({2'b00, light_sample}) - $signed({2'b00, prev_reg});
    assign thr  = $signed({2'b00, threshold_reg});

    always_comb
    begin
        if (diff >= thr)
        begin
            cls = CLS_RISE;
        end
        else if (diff <= -thr)
        begin
            cls = CLS_FALL;
        end
        else
        begin
            cls = CLS_FLAT;
        end
    end

    assign in_stall  = rsp.busy;
    assign in_take   = in_valid && !rsp.busy;
    assign req.start = in_take;
    assign req.cls   = cls;
    assign req.take  = rsp.done && (!out_valid_reg || !out_stall);

    lemd_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
            if (in_take)
            begin
                prev_reg <= light_sample;
            end
            if (req.take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cls_reg <= cls;
        end
        if (req.take)
        begin
            status_out_reg <= rsp.status;
            cls_out_reg    <= cls_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign marker_status = status_out_reg;
    assign edge_class    = cls_out_reg;

    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted word did not start a scan");

    a_out_from_scan : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(rsp.done))
        else $error("output word without a finished scan");

    a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (rsp.status == ST_NONE || rsp.status == ST_MARKER ||
                      rsp.status == ST_POSSIBLE))
        else $error("scan ended with an invalid status");

    a_take_loads : assert property (@(posedge clk) disable iff (!rst_n)
        req.take |=> out_valid_reg && !rsp.done)
        else $error("finished scan not moved to output");

endmodule
